@@ hdl/wpmt_pkg.sv @@
// ---------------------------------------------------------------------------
// wpmt_pkg
// Shared types, codes and helpers of the walking-pattern memory test unit.
// ---------------------------------------------------------------------------
package wpmt_pkg;

	// field widths
	localparam int ADDR_W = 24;
	localparam int DATA_W = 32;
	localparam int ERR_W  = 16;
	localparam int PASS_W = 32;
	localparam int FUNC_W = 2;
	localparam int IDX_W  = 2;
	localparam int CFG_W  = 24;

	localparam int DEF_WORD_ADDR_BITS = 24;

	// pattern start positions per pass
	localparam int POS33_W = 6;
	localparam int POS17_W = 5;
	localparam logic [POS33_W-1:0] POS33_LAST = POS33_W'(32);
	localparam logic [POS17_W-1:0] POS17_LAST = POS17_W'(16);

	localparam logic [DATA_W-1:0] MASK32 = '1;
	localparam logic [DATA_W-1:0] MASK16 = DATA_W'(16'hFFFF);

	// input item functions
	localparam logic [FUNC_W-1:0] FUNC_NEXT      = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_READ_DATA = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESTART   = 2'd2;

	// register indexes
	localparam logic [IDX_W-1:0] REG_WIDTH_MODE = 2'd0;
	localparam logic [IDX_W-1:0] REG_START_WORD = 2'd1;
	localparam logic [IDX_W-1:0] REG_END_WORD   = 2'd2;
	localparam logic [IDX_W-1:0] REG_MAX_ERRORS = 2'd3;

	// phases of one pass
	localparam logic [1:0] PH_WRITE0 = 2'd0;
	localparam logic [1:0] PH_CHECK0 = 2'd1;
	localparam logic [1:0] PH_WRITE1 = 2'd2;
	localparam logic [1:0] PH_CHECK1 = 2'd3;

	typedef enum logic [1:0] {
		KIND_IDLE  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_READ  = 2'd2,
		KIND_CHECK = 2'd3
	} kind_t;

	typedef struct packed {
		logic              width_mode;
		logic [ADDR_W-1:0] start_word;
		logic [ADDR_W-1:0] end_word;
		logic [ERR_W-1:0]  max_errors;
	} cfg_t;

	typedef struct packed {
		kind_t             kind;
		logic [ADDR_W-1:0] word_index;
		logic [DATA_W-1:0] data_word;
		logic              mismatch;
		logic [ERR_W-1:0]  error_count;
		logic [PASS_W-1:0] pass_number;
		logic              finished;
	} result_t;

	// first walking-one word of a pass; start at the word width is all-zero
	function automatic logic [DATA_W-1:0] first_pattern(
		input logic               mode,
		input logic [POS33_W-1:0] pos33,
		input logic [POS17_W-1:0] pos17
	);
		logic [POS33_W-1:0] pos;
		logic [POS33_W-1:0] top;
		pos = mode ? {1'b0, pos17} : pos33;
		top = mode ? POS33_W'(16) : POS33_W'(32);
		if (pos >= top) begin
			return '0;
		end
		return DATA_W'(1) << pos;
	endfunction

endpackage

@@ hdl/walking_pattern_memory_test_unit.sv @@
// ---------------------------------------------------------------------------
// walking_pattern_memory_test_unit
// Walking-zero / walking-one memory test sequencer, one command per item.
// ---------------------------------------------------------------------------
// Each accepted item updates the sequencer state and pushes its result into
// the output buffer at the edge of the transfer: into the output register
// when it is free or being read, else into the skid entry. One item is taken
// every cycle while input ready is high. That rate is set by the single
// next-state path from the state register through the pointer increment and
// range compare. A two-entry output buffer lets one more item in while a
// result waits; input ready drops only when both entries are full. There is
// no clearing pass after reset. Registers may be written only while no transfer is in flight.
module walking_pattern_memory_test_unit #(
	parameter int WORD_ADDR_BITS = wpmt_pkg::DEF_WORD_ADDR_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_we,
	input  logic [wpmt_pkg::IDX_W-1:0]  cfg_index,
	input  logic [wpmt_pkg::CFG_W-1:0]  cfg_data,
	// input channel
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [wpmt_pkg::FUNC_W-1:0] func,
	input  logic [wpmt_pkg::DATA_W-1:0] read_data,
	// result channel
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  kind,
	output logic [wpmt_pkg::ADDR_W-1:0] word_index,
	output logic [wpmt_pkg::DATA_W-1:0] data_word,
	output logic                        mismatch,
	output logic [wpmt_pkg::ERR_W-1:0]  error_count,
	output logic [wpmt_pkg::PASS_W-1:0] pass_number,
	output logic                        finished
);
	import wpmt_pkg::*;

	cfg_t    cfg;
	result_t core_res;
	result_t out_res;
	logic    fire;

	assign fire = in_valid && in_ready;

	wpmt_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	wpmt_core #(
		.WORD_ADDR_BITS (WORD_ADDR_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.fire      (fire),
		.func      (func),
		.read_data (read_data),
		.res       (core_res)
	);

	wpmt_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fire),
		.push_data (core_res),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_res)
	);

	// result fields
	assign kind        = out_res.kind;
	assign word_index  = out_res.word_index;
	assign data_word   = out_res.data_word;
	assign mismatch    = out_res.mismatch;
	assign error_count = out_res.error_count;
	assign pass_number = out_res.pass_number;
	assign finished    = out_res.finished;

endmodule

@@ hdl/wpmt_cfg_regs.sv @@
// ---------------------------------------------------------------------------
// wpmt_cfg_regs
// Configuration register file, written through a plain write port.
// ---------------------------------------------------------------------------
module wpmt_cfg_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [wpmt_pkg::IDX_W-1:0] cfg_index,
	input  logic [wpmt_pkg::CFG_W-1:0] cfg_data,
	output wpmt_pkg::cfg_t        cfg
);
	import wpmt_pkg::*;

	cfg_t cfg_q;

	// register writes, decoded by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH_MODE: cfg_q.width_mode <= cfg_data[0];
				REG_START_WORD: cfg_q.start_word <= cfg_data[ADDR_W-1:0];
				REG_END_WORD:   cfg_q.end_word   <= cfg_data[ADDR_W-1:0];
				REG_MAX_ERRORS: cfg_q.max_errors <= cfg_data[ERR_W-1:0];
				default:        cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/wpmt_core.sv @@
// ---------------------------------------------------------------------------
// wpmt_core
// Test sequencer state and its single-pass next-state and result logic.
// ---------------------------------------------------------------------------
module wpmt_core #(
	parameter int WORD_ADDR_BITS = wpmt_pkg::DEF_WORD_ADDR_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wpmt_pkg::cfg_t              cfg,
	input  logic                        fire,
	input  logic [wpmt_pkg::FUNC_W-1:0] func,
	input  logic [wpmt_pkg::DATA_W-1:0] read_data,
	output wpmt_pkg::result_t           res
);
	import wpmt_pkg::*;

	// pointer holds the memory size itself, and the 24-bit range fields
	localparam int PTR_W = ((WORD_ADDR_BITS > ADDR_W) ? WORD_ADDR_BITS : ADDR_W) + 1;

	typedef struct packed {
		logic               started;
		logic [PASS_W-1:0]  pass_count;
		logic [POS33_W-1:0] pos33;
		logic [POS17_W-1:0] pos17;
		logic [1:0]         phase;
		logic [PTR_W-1:0]   ptr;
		logic [DATA_W-1:0]  walk;
		logic               pending;
		logic [ERR_W-1:0]   errors;
		logic               done;
	} state_t;

	state_t st_q;
	state_t st_d;

	// effective range, to be kept fixed by the user while items are in flight (not enforced here)
	logic [PTR_W-1:0]  mem_words;
	logic [PTR_W-1:0]  range_end;
	logic [PTR_W-1:0]  start_ext;
	logic              range_ok;
	logic [DATA_W-1:0] mask;

	assign mem_words = PTR_W'(1) << WORD_ADDR_BITS;
	assign start_ext = PTR_W'(cfg.start_word);
	assign range_end = (cfg.end_word != '0) ? PTR_W'(cfg.end_word) : mem_words;
	assign range_ok  = !((range_end > mem_words) || (start_ext >= range_end));
	assign mask      = cfg.width_mode ? MASK16 : MASK32;

	// next state and result for the item at the input
	always_comb begin
		logic              adv;
		logic [DATA_W-1:0] expect_w;
		st_d     = st_q;
		adv      = 1'b0;
		expect_w = '0;
		res      = '0;
		res.kind = KIND_IDLE;

		case (func)
			FUNC_RESTART: begin
				st_d = '0;
			end
			FUNC_READ_DATA: begin
				if (!st_q.done && st_q.pending) begin
					expect_w = (st_q.phase < PH_WRITE1) ? (~st_q.walk & mask)
					                                    : (st_q.walk & mask);
					st_d.pending   = 1'b0;
					res.kind       = KIND_CHECK;
					res.word_index = st_q.ptr[ADDR_W-1:0];
					res.data_word  = expect_w;
					res.mismatch   = (read_data & mask) != expect_w;
					if (res.mismatch) begin
						if (st_q.errors != '1) begin
							st_d.errors = st_q.errors + ERR_W'(1);
						end
						if (st_d.errors >= cfg.max_errors) begin
							st_d.done = 1'b1;
						end
					end
					adv = !st_d.done;
				end
			end
			FUNC_NEXT: begin
				if (!st_q.done && !st_q.pending) begin
					if (!range_ok) begin
						st_d.done = 1'b1;
					end else begin
						if (!st_q.started) begin
							st_d.started    = 1'b1;
							st_d.pass_count = PASS_W'(1);
							st_d.pos33      = POS33_W'(1);
							st_d.pos17      = POS17_W'(1);
							st_d.phase      = PH_WRITE0;
							st_d.ptr        = start_ext;
						end
						// first item, or range moved under a running test: restart the phase at the start word
						if (!st_q.started || st_q.ptr < start_ext || st_q.ptr >= range_end) begin
							st_d.ptr  = start_ext;
							st_d.walk = first_pattern(cfg.width_mode, st_d.pos33, st_d.pos17);
						end
						expect_w = (st_d.phase < PH_WRITE1) ? (~st_d.walk & mask)
						                                    : (st_d.walk & mask);
						res.word_index = st_d.ptr[ADDR_W-1:0];
						res.data_word  = expect_w;
						if (st_d.phase == PH_WRITE0 || st_d.phase == PH_WRITE1) begin
							res.kind = KIND_WRITE;
							adv      = 1'b1;
						end else begin
							res.kind     = KIND_READ;
							st_d.pending = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase

		// step to the next word, phase and pass, or finish the test
		if (adv) begin
			st_d.walk = (st_d.walk != '0) ? ((st_d.walk << 1) & mask) : DATA_W'(1);
			st_d.ptr  = st_d.ptr + PTR_W'(1);
			if (!range_ok) begin
				st_d.done = 1'b1;
			end else if (st_d.ptr >= range_end) begin
				st_d.ptr = start_ext;
				if (st_d.phase == PH_CHECK1) begin
					if (cfg.max_errors == '0) begin
						st_d.done = 1'b1;
					end else begin
						st_d.pass_count = st_d.pass_count + PASS_W'(1);
						st_d.pos33 = (st_d.pos33 == POS33_LAST) ? '0 : st_d.pos33 + POS33_W'(1);
						st_d.pos17 = (st_d.pos17 == POS17_LAST) ? '0 : st_d.pos17 + POS17_W'(1);
						st_d.phase = PH_WRITE0;
						st_d.walk  = first_pattern(cfg.width_mode, st_d.pos33, st_d.pos17);
					end
				end else begin
					st_d.phase = st_d.phase + 2'd1;
					st_d.walk  = first_pattern(cfg.width_mode, st_d.pos33, st_d.pos17);
				end
			end
		end

		res.error_count = st_d.errors;
		res.pass_number = st_d.pass_count;
		res.finished    = st_d.done;
	end

	// state register, updated on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (fire) begin
			st_q <= st_d;
		end
	end

endmodule

@@ hdl/wpmt_out_buf.sv @@
// ---------------------------------------------------------------------------
// wpmt_out_buf
// Two-entry result buffer: output register plus skid stage.
// ---------------------------------------------------------------------------
module wpmt_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  wpmt_pkg::result_t push_data,
	output logic              can_push,
	output logic              out_valid,
	input  logic              out_ready,
	output wpmt_pkg::result_t out_data
);
	import wpmt_pkg::*;

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;

	assign pop      = main_valid_q && out_ready;
	assign can_push = !skid_valid_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				main_valid_q <= push;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

	assign out_valid = main_valid_q;
	assign out_data  = main_q;

endmodule
